@@ design/overwriting_ring_stack_unit_defines.svh @@
// -----------------------------------------------------------------------------
// Overwriting ring stack assertion macros
// Shared concurrent assertion wrappers for the ring stack checkers.
// -----------------------------------------------------------------------------
`ifndef OVERWRITING_RING_STACK_UNIT_DEFINES_SVH
`define OVERWRITING_RING_STACK_UNIT_DEFINES_SVH

// Assert a property outside reset.
`define ORS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert a property at every edge, reset included.
`define ORS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/ors_pkg.sv @@
// -----------------------------------------------------------------------------
// Overwriting ring stack package
// Shared constants, command codes and transfer types of the ring stack.
// -----------------------------------------------------------------------------
package ors_pkg;

  // Default sizing
  localparam int unsigned CapacityDefault  = 15;
  localparam int unsigned ElemWidthDefault = 8;

  // Fixed field widths of the transfer payloads
  localparam int unsigned ValueW = 8;
  localparam int unsigned DepthW = 4;
  localparam int unsigned CountW = 4;

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_PEEK  = 2'd3
  } cmd_e;

  // Input transfer
  typedef struct packed {
    cmd_e              command;
    logic [ValueW-1:0] push_value;
    logic [DepthW-1:0] depth_index;
  } in_item_t;

  // Result transfer
  typedef struct packed {
    logic [ValueW-1:0] top_value;
    logic [ValueW-1:0] bottom_value;
    logic [ValueW-1:0] indexed_value;
    logic [CountW-1:0] count;
    logic              is_empty;
    logic              is_full;
  } out_item_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic push;    // take the neighbor above (toward the top)
    logic rotate;  // take the neighbor below, wrapping at the end
  } cell_ctrl_t;

endpackage

@@ design/ors_cell.sv @@
// -----------------------------------------------------------------------------
// Ring stack cell
// One slot of the ring, stored relative to the top; shifts to its neighbors
// and offers its value on the indexed and bottom read buses.
// -----------------------------------------------------------------------------
module ors_cell import ors_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = ElemWidthDefault,
  parameter int unsigned IDXW       = 4,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [ELEM_WIDTH-1:0] prev_i,
  input  logic [ELEM_WIDTH-1:0] next_i,
  input  logic [IDXW-1:0]       depth_sel_i,
  input  logic [IDXW-1:0]       bottom_sel_i,
  output logic [ELEM_WIDTH-1:0] value_o,
  output logic [ELEM_WIDTH-1:0] depth_val_o,
  output logic [ELEM_WIDTH-1:0] bottom_val_o
);

  localparam logic [IDXW-1:0] MyIdx = IDXW'(INDEX);

  logic [ELEM_WIDTH-1:0] val_d, val_q;

  // Shift toward the bottom on push, toward the top on rotate
  always_comb begin
    val_d = val_q;
    if (ctrl_i.push) begin
      val_d = prev_i;
    end else if (ctrl_i.rotate) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign value_o      = val_q;
  // Drive the read buses only when selected
  assign depth_val_o  = (depth_sel_i == MyIdx) ? val_q : '0;
  assign bottom_val_o = (bottom_sel_i == MyIdx) ? val_q : '0;

endmodule

@@ design/overwriting_ring_stack_unit.sv @@
// -----------------------------------------------------------------------------
// Overwriting ring stack unit
// LIFO of up to CAPACITY elements that drops its oldest entry on overflow.
// -----------------------------------------------------------------------------
// The ring of CAPACITY+1 slots is a chain of cells kept aligned to the top:
// cell 0 holds the top entry, cell k the slot k below it. A push shifts the
// chain down one cell and a pop rotates it up one. The chain settles at the
// accepting edge, and the result register loads once any clear rotation is
// done and no stalled result is held; no new command is taken until then. A
// clear re-aligns the ring to slot zero by rotating the chain one cell per
// cycle until the top pointer (0 to CAPACITY) is back at zero. A stalled
// result holds off the load of the next one. The slot contents clear to zero
// only on reset.
module overwriting_ring_stack_unit import ors_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDefault,
  parameter int unsigned ELEM_WIDTH = ElemWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned NSlot = CAPACITY + 1;
  localparam int unsigned IDXW  = $clog2(NSlot);
  localparam int unsigned DW    = (IDXW + 1 > 5) ? IDXW + 1 : 5;
  localparam logic [IDXW-1:0] LastIdx = IDXW'(CAPACITY);

  logic [IDXW-1:0] tp_d, tp_q;
  logic [IDXW-1:0] cnt_d, cnt_q;
  logic [IDXW-1:0] depth_d, depth_q;
  logic            pend_d, pend_q;
  logic            clr_d, clr_q;
  logic            out_valid_d, out_valid_q;
  out_item_t       out_d, out_q;

  logic            accept;
  logic            load;
  cell_ctrl_t      ctrl;
  logic [IDXW-1:0] depth_red;
  logic [DW-1:0]   depth_acc;
  logic [IDXW-1:0] bottom_sel;

  logic [ELEM_WIDTH-1:0] push_elem;
  logic [ELEM_WIDTH-1:0] cell_val   [NSlot];
  logic [ELEM_WIDTH-1:0] depth_val  [NSlot];
  logic [ELEM_WIDTH-1:0] bottom_val [NSlot];
  logic [ELEM_WIDTH-1:0] depth_rd;
  logic [ELEM_WIDTH-1:0] bottom_rd;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = pend_q | clr_q;
  assign load       = pend_q & ~clr_q & (~out_valid_q | ~out_stall_i);
  assign push_elem  = ELEM_WIDTH'(in_data_i.push_value);

  // Reduce the depth modulo the ring size
  always_comb begin
    depth_acc = DW'(in_data_i.depth_index);
    for (int i = 0; i < 8; i++) begin
      if (depth_acc >= DW'(NSlot)) begin
        depth_acc = depth_acc - DW'(NSlot);
      end
    end
    depth_red = IDXW'(depth_acc);
  end

  // Command decode, pointer and count update, clear rotation
  always_comb begin
    ctrl    = '0;
    tp_d    = tp_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    pend_d  = pend_q;
    depth_d = depth_q;
    if (clr_q) begin
      ctrl.rotate = 1'b1;
      tp_d        = tp_q - IDXW'(1);
      clr_d       = (tp_q != IDXW'(1));
    end else if (accept) begin
      pend_d  = 1'b1;
      depth_d = depth_red;
      unique case (in_data_i.command)
        CMD_PUSH: begin
          ctrl.push = 1'b1;
          tp_d      = (tp_q == LastIdx) ? '0 : tp_q + IDXW'(1);
          if (cnt_q != LastIdx) begin
            cnt_d = cnt_q + IDXW'(1);
          end
        end
        CMD_POP: begin
          if (cnt_q != '0) begin
            ctrl.rotate = 1'b1;
            tp_d        = (tp_q == '0) ? LastIdx : tp_q - IDXW'(1);
            cnt_d       = cnt_q - IDXW'(1);
          end
        end
        CMD_CLEAR: begin
          cnt_d = '0;
          clr_d = (tp_q != '0);
        end
        CMD_PEEK: begin
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      pend_d = 1'b0;
    end
  end

  // Chain of slot cells
  for (genvar k = 0; k < NSlot; k++) begin : g_cell
    ors_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .IDXW      (IDXW),
      .INDEX     (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_i      ((k == 0) ? push_elem : cell_val[(k + NSlot - 1) % NSlot]),
      .next_i      (cell_val[(k + 1) % NSlot]),
      .depth_sel_i (depth_q),
      .bottom_sel_i(bottom_sel),
      .value_o     (cell_val[k]),
      .depth_val_o (depth_val[k]),
      .bottom_val_o(bottom_val[k])
    );
  end

  // Bottom sits count-1 cells below the top; on an empty stack the last cell
  assign bottom_sel = (cnt_q == '0) ? LastIdx : cnt_q - IDXW'(1);

  // Merge the selected cells onto the read buses
  always_comb begin
    depth_rd  = '0;
    bottom_rd = '0;
    for (int k = 0; k < NSlot; k++) begin
      depth_rd  = depth_rd | depth_val[k];
      bottom_rd = bottom_rd | bottom_val[k];
    end
  end

  // Form the result from the settled state
  always_comb begin
    out_d               = out_q;
    out_valid_d         = out_valid_q & out_stall_i;
    if (load) begin
      out_valid_d         = 1'b1;
      out_d.top_value     = ValueW'(cell_val[0]);
      out_d.bottom_value  = ValueW'(bottom_rd);
      out_d.indexed_value = ValueW'(depth_rd);
      out_d.count         = CountW'(cnt_q);
      out_d.is_empty      = (cnt_q == '0);
      out_d.is_full       = (cnt_q == LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q        <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tp_q        <= tp_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/ors_checker.sv @@
// -----------------------------------------------------------------------------
// Overwriting ring stack checker
// Port-level assertions on the ring stack, bound to the top level.
// -----------------------------------------------------------------------------
`include "overwriting_ring_stack_unit_defines.svh"

module ors_checker import ors_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // No result may show while in reset
  `ORS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")

  // A stalled result stays offered
  `ORS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

  // One command at a time: an accepted transfer blocks the next cycle
  `ORS_ASSERT(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o, "second command taken")

  // A new result only follows work in progress
  `ORS_ASSERT(a_result_has_cause, $rose(out_valid_o) |-> $past(in_stall_o), "result without command")

  // Flags agree with each other and the count
  `ORS_ASSERT(a_flags_consistent,
              out_valid_o |-> !(out_data_o.is_empty && out_data_o.is_full) &&
                              (!out_data_o.is_empty || out_data_o.count == '0),
              "inconsistent stack flags")

endmodule

bind overwriting_ring_stack_unit ors_checker u_ors_checker (.*);

@@ tb/overwriting_ring_stack_unit_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Overwriting ring stack checker
// Watches both channels of the ring stack, tracks the ring on every accepted
// command and compares each result transfer, field by field, in order.
// -----------------------------------------------------------------------------
module overwriting_ring_stack_unit_checker import ors_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  input  logic      wrap_up_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int unsigned RingSlots = CapacityDefault + 1;
  localparam int unsigned PrintCap  = 40;

  // Shadow ring: slot contents plus top (next free) and bottom (oldest) indexes
  logic [ValueW-1:0] slot_shadow [RingSlots];
  int unsigned       top_idx;
  int unsigned       bottom_idx;
  out_item_t         expected_views [$];
  int                fail_total;
  bit                wrapped;

  function automatic int unsigned ring_add(int unsigned p, int unsigned delta);
    return (p + delta) % RingSlots;
  endfunction

  // Apply one command to the shadow ring and return the view after it
  function automatic out_item_t apply_stack_cmd(in_item_t cmd);
    out_item_t   view;
    int unsigned depth;
    depth = cmd.depth_index % RingSlots;
    case (cmd.command)
      CMD_PUSH: begin
        slot_shadow[top_idx] = cmd.push_value;
        top_idx = ring_add(top_idx, 1);
        // drop the oldest entry when the ring wraps onto it
        if (top_idx == bottom_idx) bottom_idx = ring_add(bottom_idx, 1);
      end
      CMD_POP: begin
        if (top_idx != bottom_idx) top_idx = ring_add(top_idx, RingSlots - 1);
      end
      CMD_CLEAR: begin
        top_idx    = 0;
        bottom_idx = 0;
      end
      default: ;
    endcase
    view.top_value     = slot_shadow[ring_add(top_idx, RingSlots - 1)];
    view.bottom_value  = slot_shadow[bottom_idx];
    view.indexed_value = slot_shadow[ring_add(top_idx, 2 * RingSlots - 1 - depth)];
    view.count         = CountW'(ring_add(top_idx, RingSlots - bottom_idx));
    view.is_empty      = (top_idx == bottom_idx);
    view.is_full       = (ring_add(top_idx, 1) == bottom_idx);
    return view;
  endfunction

  task automatic report_mismatch(string what);
    fail_total++;
    if (fail_total <= PrintCap) $display("[%0t] ERROR: %s", $time, what);
  endtask

  // Track commands and compare results at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (slot_shadow[i]) slot_shadow[i] = '0;
      top_idx    = 0;
      bottom_idx = 0;
      expected_views.delete();
      fail_total = 0;
      wrapped    = 1'b0;
    end else begin
      // check the result first: it always belongs to an older command
      if (out_valid_i && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          report_mismatch("result transfer with no command outstanding");
        end else begin
          want = expected_views.pop_front();
          if (out_data_i.top_value !== want.top_value)
            report_mismatch($sformatf("top_value got %h want %h",
                                      out_data_i.top_value, want.top_value));
          if (out_data_i.bottom_value !== want.bottom_value)
            report_mismatch($sformatf("bottom_value got %h want %h",
                                      out_data_i.bottom_value, want.bottom_value));
          if (out_data_i.indexed_value !== want.indexed_value)
            report_mismatch($sformatf("indexed_value got %h want %h",
                                      out_data_i.indexed_value, want.indexed_value));
          if (out_data_i.count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d",
                                      out_data_i.count, want.count));
          if (out_data_i.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b want %b",
                                      out_data_i.is_empty, want.is_empty));
          if (out_data_i.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %b want %b",
                                      out_data_i.is_full, want.is_full));
        end
      end
      if (in_valid_i && !in_stall_i) expected_views.push_back(apply_stack_cmd(in_data_i));
      // flag results that never showed up
      if (wrap_up_i && !wrapped) begin
        wrapped = 1'b1;
        if (expected_views.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_views.size()));
      end
    end
    fail_count_o <= fail_total;
    pending_o    <= expected_views.size();
  end

endmodule

@@ tb/overwriting_ring_stack_unit_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Overwriting ring stack testbench
// Drives directed and biased random stack commands under varying sender gaps
// and receiver stalls; a checker beside the block predicts every result.
// -----------------------------------------------------------------------------
module overwriting_ring_stack_unit_tb;
  import ors_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PhaseItems = 500;
  localparam int unsigned TailCycles = 40;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_data;
  logic      wrap_up     = 1'b0;
  int        fail_count;
  int        pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cmd_tally [4] = '{0, 0, 0, 0};
  int unsigned idle_cycles = 0;

  always #10 clk = ~clk;

  overwriting_ring_stack_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  overwriting_ring_stack_unit_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .wrap_up_i   (wrap_up),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Randomize receiver back-pressure every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("overwriting_ring_stack_unit verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_item_t stack_cmd(cmd_e op, logic [ValueW-1:0] value,
                                         logic [DepthW-1:0] depth);
    in_item_t item;
    item.command     = op;
    item.push_value  = value;
    item.depth_index = depth;
    return item;
  endfunction

  // Offer one command, with a random gap first, and hold it until the transfer
  task automatic send_cmd(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmd_tally[item.command]++;
  endtask

  // Pick a command; fill bias drives the ring into overflow, drain bias empties it
  function automatic cmd_e pick_op(bit fill_bias);
    int unsigned r;
    r = $urandom_range(99);
    if (fill_bias) begin
      if (r < 60) return CMD_PUSH;
      if (r < 80) return CMD_POP;
      if (r < 83) return CMD_CLEAR;
      return CMD_PEEK;
    end
    if (r < 25) return CMD_PUSH;
    if (r < 75) return CMD_POP;
    if (r < 80) return CMD_CLEAR;
    return CMD_PEEK;
  endfunction

  task automatic run_random(int sender_pct, int receiver_pct, int unsigned n);
    bit fill_bias;
    fill_bias      = 1'b1;
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    for (int unsigned k = 0; k < n; k++) begin
      // flip the bias now and then so the ring swings between empty and full
      if (k % 48 == 0) fill_bias = 1'($urandom_range(1));
      send_cmd(stack_cmd(pick_op(fill_bias), ValueW'($urandom),
                         DepthW'($urandom_range(15))));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, deep peek, fill past capacity, wrap, clear, stale reads
    send_idle_pct  = 21;
    recv_stall_pct = 50;
    send_cmd(stack_cmd(CMD_POP, 8'h00, 4'd0));
    send_cmd(stack_cmd(CMD_PEEK, 8'hFF, 4'd15));
    for (int k = 0; k < CapacityDefault + 1; k++) begin
      send_cmd(stack_cmd(CMD_PUSH,
                         (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : ValueW'(k * 37 + 5),
                         DepthW'(k)));
    end
    send_cmd(stack_cmd(CMD_PEEK, 8'h00, 4'd15));
    send_cmd(stack_cmd(CMD_POP, 8'h00, 4'd1));
    send_cmd(stack_cmd(CMD_CLEAR, 8'h00, 4'd0));
    send_cmd(stack_cmd(CMD_PEEK, 8'h00, 4'd5));
    send_cmd(stack_cmd(CMD_POP, 8'h00, 4'd0));
    send_cmd(stack_cmd(CMD_PUSH, 8'hC3, 4'd15));

    // Random: three back-pressure mixes, the last with no idling at all
    run_random(21, 50, PhaseItems);
    run_random(50, 21, PhaseItems);
    run_random(0, 0, PhaseItems);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d commands: %0d push, %0d pop, %0d clear, %0d peek",
             cmd_tally[CMD_PUSH] + cmd_tally[CMD_POP] + cmd_tally[CMD_CLEAR]
             + cmd_tally[CMD_PEEK], cmd_tally[CMD_PUSH], cmd_tally[CMD_POP],
             cmd_tally[CMD_CLEAR], cmd_tally[CMD_PEEK]);
    $display("Back-pressure mixes: sender-light, receiver-light and unthrottled");
    if (fail_count == 0) begin
      $display("overwriting_ring_stack_unit verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("overwriting_ring_stack_unit verification failed");
    end
    $finish;
  end

endmodule

@@ overwriting_ring_stack_unit.f @@
+incdir+design
design/ors_pkg.sv
design/ors_cell.sv
design/overwriting_ring_stack_unit.sv
design/ors_checker.sv
tb/overwriting_ring_stack_unit_checker.sv
tb/overwriting_ring_stack_unit_tb.sv
